@@ src/dcc_pkg.sv @@
`default_nettype none

package dcc_pkg;

  localparam int unsigned PaddrW = 5;

  // register indexes on the configuration port
  localparam logic [2:0] RegChanCount   = 3'd0;
  localparam logic [2:0] RegFullScale   = 3'd1;
  localparam logic [2:0] RegRawMode     = 3'd2;
  localparam logic [2:0] RegBufferLen   = 3'd3;
  localparam logic [2:0] RegRecycle     = 3'd4;

  localparam logic ModeSample = 1'b0;
  localparam logic ModeEntry  = 1'b1;

  typedef struct packed {
    logic [4:0]  chan_count;
    logic [31:0] full_scale;
    logic        raw_mode;
    logic [31:0] buffer_length;
    logic        recycle;
  } dcc_cfg_t;

  typedef struct packed {
    logic signed [47:0] slope;
    logic signed [47:0] offset;
    logic               analog;
  } dcc_entry_t;

  // per-sample bookkeeping that travels alongside the arithmetic
  typedef struct packed {
    logic signed [39:0] sample;
    logic [3:0]         ch;
    logic               in_range;
    logic               bend;
    logic               adone;
    logic [47:0]        total;
  } dcc_meta_t;

endpackage

`default_nettype wire

@@ src/dcc_ram.sv @@
`default_nettype none

module dcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/dcc_cfg.sv @@
`default_nettype none

module dcc_cfg
  import dcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output dcc_cfg_t               cfg_o
);

  dcc_cfg_t   cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        RegChanCount: cfg_d.chan_count    = pwdata[4:0];
        RegFullScale: cfg_d.full_scale    = pwdata;
        RegRawMode:   cfg_d.raw_mode      = pwdata[0];
        RegBufferLen: cfg_d.buffer_length = pwdata;
        RegRecycle:   cfg_d.recycle       = pwdata[0];
        default:      cfg_d               = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegChanCount: prdata = {27'd0, cfg_q.chan_count};
      RegFullScale: prdata = cfg_q.full_scale;
      RegRawMode:   prdata = {31'd0, cfg_q.raw_mode};
      RegBufferLen: prdata = cfg_q.buffer_length;
      RegRecycle:   prdata = {31'd0, cfg_q.recycle};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan_count    <= 5'd1;
      cfg_q.full_scale    <= 32'd65535;
      cfg_q.raw_mode      <= 1'b0;
      cfg_q.buffer_length <= 32'd1;
      cfg_q.recycle       <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ src/dcc_calc.sv @@
`default_nettype none

module dcc_calc
  import dcc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire dcc_meta_t   meta_i,
  input  wire dcc_entry_t  entry_i,
  input  wire dcc_cfg_t    cfg_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      dac_code_o,
  output logic [3:0]       code_channel_o,
  output logic             buffer_end_o,
  output logic             all_done_o,
  output logic [47:0]      samples_sent_o
);

  localparam logic [31:0] CodeMax = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic [31:0] upper;
  assign upper = (cfg_i.full_scale < CodeMax) ? cfg_i.full_scale : CodeMax;

  // stage handshakes: a stage loads when empty or when its successor moves
  logic v2_q, v3_q, v4_q, vo_q;
  logic en2, en3, en4, eno;
  assign eno     = !vo_q || !out_stall_i;
  assign en4     = !v4_q || eno;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign ready_o = en2;

  // ---- stage 1: table entry present, partial products and bypass code
  logic               analog1, calib1;
  logic [31:0]        sint1, alt1;
  logic [19:0]        s_lo;
  logic [19:0]        s_hi;
  logic [23:0]        m_lo;
  logic [23:0]        m_hi;
  logic [43:0]        pp_ll_d;
  logic signed [44:0] pp_hl_d, pp_lh_d;
  logic signed [43:0] pp_hh_d;

  assign analog1 = meta_i.in_range && entry_i.analog;
  assign calib1  = analog1 && !cfg_i.raw_mode;
  assign sint1   = meta_i.sample[39] ? 32'd0 : {8'd0, meta_i.sample[39:16]};
  assign s_lo    = meta_i.sample[19:0];
  assign s_hi    = meta_i.sample[39:20];
  assign m_lo    = entry_i.slope[23:0];
  assign m_hi    = entry_i.slope[47:24];

  always_comb begin
    if (analog1) begin
      alt1 = (sint1 > upper) ? upper : sint1;
    end else begin
      alt1 = (sint1 > CodeMax) ? CodeMax : sint1;
    end
  end

  assign pp_ll_d = 44'(s_lo) * 44'(m_lo);
  assign pp_hl_d = $signed(s_hi) * $signed({1'b0, m_lo});
  assign pp_lh_d = $signed({1'b0, s_lo}) * $signed(m_hi);
  assign pp_hh_d = $signed(s_hi) * $signed(m_hi);

  dcc_meta_t          meta2_q;
  logic               calib2_q;
  logic [31:0]        alt2_q;
  logic [43:0]        pp_ll_q;
  logic signed [44:0] pp_hl_q, pp_lh_q;
  logic signed [43:0] pp_hh_q;
  logic signed [47:0] off2_q;

  // ---- stage 2: fold partial products and the aligned offset
  logic signed [87:0] pa_d;
  logic signed [88:0] pb_d, hl_x, lh_x, off_x;

  assign pa_d  = {pp_hh_q, pp_ll_q};
  assign hl_x  = 89'(pp_hl_q);
  assign lh_x  = 89'(pp_lh_q);
  assign off_x = 89'(off2_q);
  assign pb_d  = (hl_x <<< 20) + (lh_x <<< 24) + (off_x <<< 24);

  dcc_meta_t          meta3_q;
  logic               calib3_q;
  logic [31:0]        alt3_q;
  logic signed [87:0] pa_q;
  logic signed [88:0] pb_q;

  // ---- stage 3: final sum, Q49.40
  logic signed [88:0] sum_d;
  assign sum_d = 89'(pa_q) + pb_q;

  dcc_meta_t          meta4_q;
  logic               calib4_q;
  logic [31:0]        alt4_q;
  logic signed [88:0] sum_q;

  // ---- stage 4: floor, clamp, select
  logic [48:0] whole;
  logic [31:0] code_d;
  assign whole = sum_q[88:40];

  always_comb begin
    if (!calib4_q) begin
      code_d = alt4_q;
    end else if (sum_q[88]) begin
      code_d = 32'd0;
    end else if (whole > {17'd0, upper}) begin
      code_d = upper;
    end else begin
      code_d = whole[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en2) v2_q <= valid_i;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      meta2_q  <= meta_i;
      calib2_q <= calib1;
      alt2_q   <= alt1;
      pp_ll_q  <= pp_ll_d;
      pp_hl_q  <= pp_hl_d;
      pp_lh_q  <= pp_lh_d;
      pp_hh_q  <= pp_hh_d;
      off2_q   <= entry_i.offset;
    end
    if (en3) begin
      meta3_q  <= meta2_q;
      calib3_q <= calib2_q;
      alt3_q   <= alt2_q;
      pa_q     <= pa_d;
      pb_q     <= pb_d;
    end
    if (en4) begin
      meta4_q  <= meta3_q;
      calib4_q <= calib3_q;
      alt4_q   <= alt3_q;
      sum_q    <= sum_d;
    end
    if (eno) begin
      dac_code_o     <= code_d;
      code_channel_o <= meta4_q.ch;
      buffer_end_o   <= meta4_q.bend;
      all_done_o     <= meta4_q.adone;
      samples_sent_o <= meta4_q.total;
    end
  end

  assign out_valid_o = vo_q;

endmodule

`default_nettype wire

@@ src/dac_channel_calibrate_clamp_core.sv @@
// An accepted sample is registered with its table read, then passes the calc stages.
// Throughput: one transaction per cycle, samples and table writes alike; while a code
// waits for the consumer the stages keep filling, and the input stalls once all are full.
// The coefficient RAM has one write and one registered read port, read in the accept cycle.
// Reset: scan/buffer counters, done flag and total clear; table contents are not cleared.
`default_nettype none

module dac_channel_calibrate_clamp_core
  import dcc_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic signed [39:0] sample_value_i,
  input  wire logic [3:0]        entry_channel_i,
  input  wire logic signed [47:0] entry_slope_i,
  input  wire logic signed [47:0] entry_offset_i,
  input  wire logic              entry_analog_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [31:0]            dac_code_o,
  output logic [3:0]             code_channel_o,
  output logic                   buffer_end_o,
  output logic                   all_done_o,
  output logic [47:0]            samples_sent_o
);

  localparam int unsigned AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [6:0]  MaxCh  = 7'(MAX_CHANNELS);
  localparam logic [4:0]  ChanCap = (MAX_CHANNELS < 16) ? 5'(MAX_CHANNELS) : 5'd16;
  localparam logic [32:0] CodeMax = 33'((64'd1 << COUNT_BITS) - 64'd1);

  dcc_cfg_t cfg;

  dcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---- front end: scan and buffer counters, table access
  logic        v1_q, en1, calc_ready, accept, sample_go, entry_wr;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] buf_q, buf_d;
  logic        done_q, done_d;
  logic [47:0] total_q, total_d;
  logic        bend, adone;
  logic [4:0]  lim, ch_next;
  logic [32:0] buf_next;
  dcc_meta_t   meta_q, meta_d;
  dcc_entry_t  wentry, rentry;

  assign en1        = !v1_q || calc_ready;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;
  assign sample_go  = accept && (mode_i == ModeSample) && !done_q;
  assign entry_wr   = accept && (mode_i == ModeEntry) && ({3'd0, entry_channel_i} < MaxCh);

  assign lim      = (cfg.chan_count > ChanCap) ? ChanCap : cfg.chan_count;
  assign ch_next  = {1'b0, pos_q} + 5'd1;
  assign buf_next = {1'b0, buf_q} + 33'd1;

  always_comb begin
    pos_d   = pos_q;
    buf_d   = buf_q;
    done_d  = done_q;
    total_d = total_q + 48'd1;
    bend    = 1'b0;
    adone   = 1'b0;
    if (buf_next >= {1'b0, cfg.buffer_length}) begin
      bend  = 1'b1;
      adone = !cfg.recycle;
    end
    if (sample_go) begin
      buf_d  = bend ? 32'd0 : buf_next[31:0];
      done_d = done_q || adone;
      pos_d  = (ch_next >= lim) ? 4'd0 : ch_next[3:0];
    end
  end

  always_comb begin
    meta_d.sample   = sample_value_i;
    meta_d.ch       = pos_q;
    meta_d.in_range = ({3'd0, pos_q} < MaxCh);
    meta_d.bend     = bend;
    meta_d.adone    = adone;
    meta_d.total    = total_d;
  end

  assign wentry.slope  = entry_slope_i;
  assign wentry.offset = entry_offset_i;
  assign wentry.analog = entry_analog_i;

  // A write and a read never belong to the same transaction, and a read the
  // cycle after a write sees the new entry, so no forwarding is needed.
  dcc_ram #(
    .WIDTH ($bits(dcc_entry_t)),
    .DEPTH (MAX_CHANNELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (entry_wr),
    .waddr_i (AW'(entry_channel_i)),
    .wdata_i (wentry),
    .re_i    (sample_go),
    .raddr_i (AW'(pos_q)),
    .rdata_o (rentry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      pos_q   <= 4'd0;
      buf_q   <= 32'd0;
      done_q  <= 1'b0;
      total_q <= 48'd0;
    end else begin
      if (en1) v1_q <= sample_go;
      if (sample_go) begin
        pos_q   <= pos_d;
        buf_q   <= buf_d;
        done_q  <= done_d;
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_go) begin
      meta_q <= meta_d;
    end
  end

  dcc_calc #(
    .COUNT_BITS (COUNT_BITS)
  ) u_calc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (v1_q),
    .meta_i         (meta_q),
    .entry_i        (rentry),
    .cfg_i          (cfg),
    .ready_o        (calc_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dac_code_o     (dac_code_o),
    .code_channel_o (code_channel_o),
    .buffer_end_o   (buffer_end_o),
    .all_done_o     (all_done_o),
    .samples_sent_o (samples_sent_o)
  );

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("done flag cleared without reset");

  a_drop_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_q) |=> !v1_q)
    else $error("sample entered pipeline after done");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_go |=> (total_q == $past(total_q) + 48'd1))
    else $error("sample total did not advance by one");

  a_done_implies_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!all_done_o || buffer_end_o))
    else $error("all_done without buffer_end");

  a_code_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, dac_code_o} <= CodeMax))
    else $error("code above code-width limit");
`endif

endmodule

`default_nettype wire
